>>> src/pnst_pkg.sv
// Shared constants for the point-near-segment test block.
`timescale 1ns / 1ps

package pnst_pkg;

  // Width and reset value of the hit band half width register.
  localparam int RANGE_BITS = 15;
  localparam logic [RANGE_BITS-1:0] RANGE_RESET = 15'd64;

  // Register stages between an accepted input word and its result word.
  localparam int PIPE_DEPTH = 8;

endpackage : pnst_pkg

>>> src/pnst_if.sv
// Valid/ready channel interfaces for the point-near-segment test block.
`timescale 1ns / 1ps

// Input channel: one word is two segment endpoints and a query point.
interface pnst_in_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] end_a_x;
  logic signed [COORD_BITS-1:0] end_a_z;
  logic signed [COORD_BITS-1:0] end_b_x;
  logic signed [COORD_BITS-1:0] end_b_z;
  logic signed [COORD_BITS-1:0] query_x;
  logic signed [COORD_BITS-1:0] query_z;

  modport source (
    output valid, end_a_x, end_a_z, end_b_x, end_b_z, query_x, query_z,
    input  ready
  );
  modport sink (
    input  valid, end_a_x, end_a_z, end_b_x, end_b_z, query_x, query_z,
    output ready
  );
endinterface : pnst_in_if

// Output channel: one word is the hit flag.
interface pnst_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface : pnst_out_if

// Configuration channel: one word is the band half width.
interface pnst_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [pnst_pkg::RANGE_BITS-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface : pnst_cfg_if

>>> src/pnst_split_mul.sv
// Three stage unsigned multiplier built from four half width partial products.
`timescale 1ns / 1ps

module pnst_split_mul #(
  parameter int AW = 16,
  parameter int BW = 16
) (
  input  logic            clk_i,
  input  logic [2:0]      en_i,
  input  logic [AW-1:0]   a_i,
  input  logic [BW-1:0]   b_i,
  output logic [AW+BW-1:0] prod_o
);

  localparam int LA  = (AW + 1) / 2;
  localparam int HA  = AW - LA;
  localparam int LB  = (BW + 1) / 2;
  localparam int HB  = BW - LB;
  localparam int PRW = AW + BW;

  logic [HA+HB-1:0] p_hh_q;
  logic [HA+LB-1:0] p_hl_q;
  logic [LA+HB-1:0] p_lh_q;
  logic [LA+LB-1:0] p_ll_q;
  logic [PRW-1:0]   cat_q;
  logic [PRW-1:0]   mid_q;
  logic [PRW-1:0]   prod_q;

  // First stage: the four partial products of the split operands.
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      p_hh_q <= a_i[AW-1:LA] * b_i[BW-1:LB];
      p_hl_q <= a_i[AW-1:LA] * b_i[LB-1:0];
      p_lh_q <= a_i[LA-1:0] * b_i[BW-1:LB];
      p_ll_q <= a_i[LA-1:0] * b_i[LB-1:0];
    end
  end

  // Second stage: the outer products do not overlap, the cross terms are added.
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      cat_q <= {p_hh_q, p_ll_q};
      mid_q <= (PRW'(p_hl_q) << LA) + (PRW'(p_lh_q) << LB);
    end
  end

  // Third stage: the final sum, exact in AW + BW bits.
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      prod_q <= cat_q + mid_q;
    end
  end

  assign prod_o = prod_q;

endmodule : pnst_split_mul

>>> src/point_near_segment_test.sv
// Top level of the point-near-segment test: an eight stage hit pipeline.
`timescale 1ns / 1ps

// Usage
// The input channel takes one word per query: endpoints a and b and a query
// point, each a signed Q12.4 coordinate in the x-z plane. The output channel
// returns one word per query, the hit flag, in the order the queries came in.
// The configuration channel writes the band half width (unsigned Q11.4); it is
// always ready outside reset. It must be written only while no query is in
// flight; the block itself does not enforce this. Throughput is one query per
// cycle while the receiver does not stall, since every stage loads in the
// cycle its word moves on. The eight register stages are differences,
// products, sums, compare and magnitude, a three stage split multiplier for
// the squared cross product and the range bound, and the final select.
// When the receiver stalls, the result word holds and the stages behind it
// keep filling their empty slots; the input channel drops ready only when
// every stage holds a word.
// Reset clears all stage valid bits and sets the half width to 4.0 (64).
// Both ready signals are low while reset is asserted.

module point_near_segment_test #(
  parameter int COORD_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pnst_cfg_if.sink  cfg_chan_i,
  pnst_in_if.sink   in_chan_i,
  pnst_out_if.source out_chan_o
);

  import pnst_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int DW    = C + 1;
  localparam int PW    = 2 * C + 2;
  localparam int SW    = 2 * C + 3;
  localparam int LW    = 2 * C + 2;
  localparam int RRW   = 2 * RANGE_BITS;
  localparam int AXW   = (DW > RANGE_BITS) ? DW : RANGE_BITS;
  localparam int CRW   = 2 * SW;
  localparam int LMW   = RRW + LW;
  localparam int CMPW  = (CRW > LMW) ? CRW : LMW;
  localparam logic [RRW-1:0] RR_RESET = RRW'(RANGE_RESET) * RRW'(RANGE_RESET);

  // Stage control.
  logic [PIPE_DEPTH:1] vld_q;
  logic [PIPE_DEPTH:1] en;

  // Configuration registers.
  logic [RANGE_BITS-1:0] range_q;
  logic [RRW-1:0]        rr_q;

  // Stage 1: differences and axis flags.
  logic signed [DW-1:0] dx_q, dz_q, wx_q, wz_q;
  logic                 vert_q, horz_q, btwx_q, btwz_q;

  // Stage 2: products and the axis parallel answer.
  logic signed [PW-1:0] p_dxwx_q, p_dzwz_q, p_dxwz_q, p_dzwx_q, sqx_q, sqz_q;
  logic [DW-1:0]        mag_x, mag_z;
  logic                 axis_q2, axhit_q2;

  // Stage 3: dot, cross and squared length.
  logic signed [SW-1:0] dot_q, crs_q;
  logic [LW-1:0]        len_q;
  logic                 axis_q3, axhit_q3;

  // Stage 4: along test and cross magnitude.
  logic [SW-1:0] cm_q;
  logic [LW-1:0] len_q4;
  logic          along_q4, axis_q4, axhit_q4;

  // Stages 5 to 7: wide squares in the split multipliers, flags alongside.
  logic [CRW-1:0]  crs2;
  logic [LMW-1:0]  lim;
  logic [7:5]      along_s_q, axis_s_q, axhit_s_q;

  // Stage 8: result word.
  logic hit_q;

  // A stage loads when it is empty or its word moves on.
  always_comb begin
    en[PIPE_DEPTH] = !vld_q[PIPE_DEPTH] || out_chan_o.ready;
    for (int k = PIPE_DEPTH - 1; k >= 1; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_chan_i.ready  = en[1] && rst_ni;
  assign cfg_chan_i.ready = rst_ni;
  assign out_chan_o.valid = vld_q[PIPE_DEPTH];
  assign out_chan_o.hit   = hit_q;

  // Valid bits travel with the words.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[1]) begin
        vld_q[1] <= in_chan_i.valid;
      end
      for (int k = 2; k <= PIPE_DEPTH; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Half width register and its square.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q <= RANGE_RESET;
      rr_q    <= RR_RESET;
    end else begin
      if (cfg_chan_i.valid) begin
        range_q <= cfg_chan_i.data;
      end
      rr_q <= RRW'(range_q) * RRW'(range_q);
    end
  end

  // Stage 1: segment direction, query offset and range checks along each axis.
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      dx_q   <= DW'(in_chan_i.end_b_x) - DW'(in_chan_i.end_a_x);
      dz_q   <= DW'(in_chan_i.end_b_z) - DW'(in_chan_i.end_a_z);
      wx_q   <= DW'(in_chan_i.query_x) - DW'(in_chan_i.end_a_x);
      wz_q   <= DW'(in_chan_i.query_z) - DW'(in_chan_i.end_a_z);
      vert_q <= in_chan_i.end_a_x == in_chan_i.end_b_x;
      horz_q <= in_chan_i.end_a_z == in_chan_i.end_b_z;
      btwx_q <= (in_chan_i.query_x >= in_chan_i.end_a_x &&
                 in_chan_i.query_x <= in_chan_i.end_b_x) ||
                (in_chan_i.query_x >= in_chan_i.end_b_x &&
                 in_chan_i.query_x <= in_chan_i.end_a_x);
      btwz_q <= (in_chan_i.query_z >= in_chan_i.end_a_z &&
                 in_chan_i.query_z <= in_chan_i.end_b_z) ||
                (in_chan_i.query_z >= in_chan_i.end_b_z &&
                 in_chan_i.query_z <= in_chan_i.end_a_z);
    end
  end

  // Distance across an axis parallel segment is the plain offset magnitude.
  assign mag_x = wx_q[DW-1] ? -wx_q : wx_q;
  assign mag_z = wz_q[DW-1] ? -wz_q : wz_q;

  // Stage 2: signed products; a vertical segment takes precedence.
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      p_dxwx_q <= dx_q * wx_q;
      p_dzwz_q <= dz_q * wz_q;
      p_dxwz_q <= dx_q * wz_q;
      p_dzwx_q <= dz_q * wx_q;
      sqx_q    <= dx_q * dx_q;
      sqz_q    <= dz_q * dz_q;
      axis_q2  <= vert_q || horz_q;
      axhit_q2 <= vert_q ? (AXW'(mag_x) < AXW'(range_q) && btwz_q)
                         : (AXW'(mag_z) < AXW'(range_q) && btwx_q);
    end
  end

  // Stage 3: dot product, cross product and squared segment length.
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      dot_q    <= SW'(p_dxwx_q) + SW'(p_dzwz_q);
      crs_q    <= SW'(p_dxwz_q) - SW'(p_dzwx_q);
      len_q    <= LW'($unsigned(sqx_q)) + LW'($unsigned(sqz_q));
      axis_q3  <= axis_q2;
      axhit_q3 <= axhit_q2;
    end
  end

  // Stage 4: the projection must land on the segment, endpoints included.
  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      along_q4 <= !dot_q[SW-1] && ($unsigned(dot_q) <= SW'(len_q));
      cm_q     <= crs_q[SW-1] ? $unsigned(-crs_q) : $unsigned(crs_q);
      len_q4   <= len_q;
      axis_q4  <= axis_q3;
      axhit_q4 <= axhit_q3;
    end
  end

  // Squared cross product, compared against range squared times length squared.
  pnst_split_mul #(
    .AW (SW),
    .BW (SW)
  ) u_crs_sq (
    .clk_i  (clk_i),
    .en_i   (en[7:5]),
    .a_i    (cm_q),
    .b_i    (cm_q),
    .prod_o (crs2)
  );

  pnst_split_mul #(
    .AW (RRW),
    .BW (LW)
  ) u_lim (
    .clk_i  (clk_i),
    .en_i   (en[7:5]),
    .a_i    (rr_q),
    .b_i    (len_q4),
    .prod_o (lim)
  );

  // Flags ride alongside the multiplier stages.
  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      along_s_q[5] <= along_q4;
      axis_s_q[5]  <= axis_q4;
      axhit_s_q[5] <= axhit_q4;
    end
    for (int k = 6; k <= 7; k++) begin
      if (en[k]) begin
        along_s_q[k] <= along_s_q[k-1];
        axis_s_q[k]  <= axis_s_q[k-1];
        axhit_s_q[k] <= axhit_s_q[k-1];
      end
    end
  end

  // Stage 8: pick the axis answer or the band test for a slanted segment.
  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      hit_q <= axis_s_q[7] ? axhit_s_q[7]
                           : (along_s_q[7] && (CMPW'(crs2) <= CMPW'(lim)));
    end
  end

endmodule : point_near_segment_test

>>> src/pnst_check.sv
// Port level checks for the point-near-segment test block, bound to the top.
`timescale 1ns / 1ps

module pnst_check (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic hit_i
);

  import pnst_pkg::*;

  localparam int CNTW = $clog2(PIPE_DEPTH + 1);

  logic            in_acc;
  logic            out_acc;
  logic [CNTW-1:0] cnt_q;
  logic [CNTW-1:0] cnt_d;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Words accepted but not yet delivered.
  always_comb begin
    cnt_d = cnt_q + CNTW'(in_acc) - CNTW'(out_acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // A stalled result word stays offered.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its value.
  a_hit_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(hit_i))
    else $error("hit changed while stalled");

  // The pipeline never holds more words than it has stages, and never offers
  // a result without a word in flight.
  a_occupancy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= CNTW'(PIPE_DEPTH)) && (!out_valid_i || cnt_q != '0))
    else $error("in-flight word count out of bounds");

  // Without back pressure a word comes out after the full pipeline latency.
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(in_acc, 8) && $past(out_ready_i, 1) && $past(out_ready_i, 2) &&
    $past(out_ready_i, 3) && $past(out_ready_i, 4) && $past(out_ready_i, 5) &&
    $past(out_ready_i, 6) && $past(out_ready_i, 7) |-> out_valid_i)
    else $error("result word late without back pressure");

endmodule : pnst_check

bind point_near_segment_test pnst_check u_pnst_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_chan_i.valid),
  .in_ready_i  (in_chan_i.ready),
  .out_valid_i (out_chan_o.valid),
  .out_ready_i (out_chan_o.ready),
  .hit_i       (out_chan_o.hit)
);

>>> dv/tb_top.sv
// Self-checking testbench for the point-near-segment hit pipeline.
`timescale 1ns / 1ps

module tb_top;

  import pnst_pkg::*;

  localparam int COORD_BITS = 16;
  localparam int IDLE_PCT = 23;
  localparam int RANDOM_PER_SETTING = 106;

  typedef logic signed [127:0] wide_t;

  // One query word as the input channel carries it.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] end_a_x;
    logic signed [COORD_BITS-1:0] end_a_z;
    logic signed [COORD_BITS-1:0] end_b_x;
    logic signed [COORD_BITS-1:0] end_b_z;
    logic signed [COORD_BITS-1:0] query_x;
    logic signed [COORD_BITS-1:0] query_z;
  } query_t;

  // Predicts the hit flag of each accepted query and checks the result words in order.
  class band_hit_checker;
    logic [RANGE_BITS-1:0] band_half_width;
    bit                    expected_hits[$];
    query_t                pending_queries[$];
    int                    mismatches;
    int                    checked;
    int                    hits_seen;

    function new();
      band_half_width = RANGE_RESET;
      mismatches = 0;
      checked = 0;
      hits_seen = 0;
    endfunction

    function void set_band(logic [RANGE_BITS-1:0] value);
      band_half_width = value;
    endfunction

    function int pending();
      return expected_hits.size();
    endfunction

    // Inclusive test that v lies between the two endpoint values.
    function bit in_span(wide_t v, wide_t e1, wide_t e2);
      wide_t lo;
      wide_t hi;
      lo = (e1 < e2) ? e1 : e2;
      hi = (e1 < e2) ? e2 : e1;
      return (v >= lo) && (v <= hi);
    endfunction

    // Exact band test; all values are held wide enough that nothing wraps.
    function bit predict_hit(query_t q);
      wide_t ax, az, bx, bz, px, pz, rng;
      wide_t dx, dz, wx, wz, dot, crs, len2, off;
      bit    hit;
      ax = $signed(q.end_a_x);
      az = $signed(q.end_a_z);
      bx = $signed(q.end_b_x);
      bz = $signed(q.end_b_z);
      px = $signed(q.query_x);
      pz = $signed(q.query_z);
      rng = {113'd0, band_half_width};
      if (ax == bx) begin
        // Vertical or zero-length segment: strict across, inclusive along.
        off = px - ax;
        if (off < 0) off = -off;
        hit = (off < rng) && in_span(pz, az, bz);
      end else if (az == bz) begin
        // Horizontal segment.
        off = pz - az;
        if (off < 0) off = -off;
        hit = (off < rng) && in_span(px, ax, bx);
      end else begin
        // Slanted segment: projection within the segment, closed band around it.
        dx = bx - ax;
        dz = bz - az;
        wx = px - ax;
        wz = pz - az;
        dot = dx * wx + dz * wz;
        crs = dx * wz - dz * wx;
        len2 = dx * dx + dz * dz;
        hit = (dot >= 0) && (dot <= len2) && (crs * crs <= rng * rng * len2);
      end
      return hit;
    endfunction

    function void note_query(query_t q);
      expected_hits.push_back(predict_hit(q));
      pending_queries.push_back(q);
    endfunction

    function void check_hit(logic actual);
      bit     want;
      query_t q;
      if (expected_hits.size() == 0) begin
        mismatches++;
        $display("%0t: result word %0b arrived with no query waiting", $time, actual);
        return;
      end
      want = expected_hits.pop_front();
      q = pending_queries.pop_front();
      checked++;
      if (actual === 1'b1) hits_seen++;
      if (actual !== want) begin
        mismatches++;
        if (mismatches <= 100)
          $display({"%0t: hit mismatch, expected %0b actual %0b, ",
                    "a=(%0d,%0d) b=(%0d,%0d) p=(%0d,%0d) range=%0d"},
                   $time, want, actual, q.end_a_x, q.end_a_z, q.end_b_x, q.end_b_z,
                   q.query_x, q.query_z, band_half_width);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   calm;
  int   settings_run;

  band_hit_checker hits = new();

  pnst_in_if #(.COORD_BITS(COORD_BITS)) in_chan ();
  pnst_out_if out_chan ();
  pnst_cfg_if cfg_chan ();

  point_near_segment_test #(
    .COORD_BITS(COORD_BITS)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_chan_i(cfg_chan),
    .in_chan_i (in_chan),
    .out_chan_o(out_chan)
  );

  // Clock with a 2 ns period.
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Receiver: stalls at random except during the calm stretch.
  always @(negedge clk_i) begin
    out_chan.ready = calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Every accepted result word is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_chan.valid && out_chan.ready) hits.check_hit(out_chan.hit);
  end

  // Hard stop in case the block hangs.
  initial begin
    #200000;
    $display("Run stopped at %0t with %0d results outstanding", $time, hits.pending());
    $display("TB_ERROR");
    $finish;
  end

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // Offer one query word, idling at random first, and hold it until accepted.
  task automatic send_query(query_t q);
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_chan.valid = 1'b0;
      @(negedge clk_i);
    end
    in_chan.valid = 1'b1;
    in_chan.end_a_x = q.end_a_x;
    in_chan.end_a_z = q.end_a_z;
    in_chan.end_b_x = q.end_b_x;
    in_chan.end_b_z = q.end_b_z;
    in_chan.query_x = q.query_x;
    in_chan.query_z = q.query_z;
    do @(posedge clk_i); while (!in_chan.ready);
    hits.note_query(q);
  endtask

  task automatic send_pts(int ax, int az, int bx, int bz, int px, int pz);
    query_t q;
    q.end_a_x = COORD_BITS'(ax);
    q.end_a_z = COORD_BITS'(az);
    q.end_b_x = COORD_BITS'(bx);
    q.end_b_z = COORD_BITS'(bz);
    q.query_x = COORD_BITS'(px);
    q.query_z = COORD_BITS'(pz);
    send_query(q);
  endtask

  // Random query, mostly a point placed near a segment of random shape and scale.
  task automatic send_random_query();
    int kind, span, ax, az, bx, bz, t, reach, px, pz;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      send_pts(rand_between(-32768, 32767), rand_between(-32768, 32767),
               rand_between(-32768, 32767), rand_between(-32768, 32767),
               rand_between(-32768, 32767), rand_between(-32768, 32767));
    end else begin
      case ($urandom_range(0, 2))
        0:       span = 64;
        1:       span = 1024;
        default: span = 32767;
      endcase
      ax = rand_between(-span, span);
      az = rand_between(-span, span);
      bx = rand_between(-span, span);
      bz = rand_between(-span, span);
      case ($urandom_range(0, 5))
        0:       bx = ax;
        1:       bz = az;
        2: begin
          bx = ax;
          bz = az;
        end
        default: ;
      endcase
      t = rand_between(-16, 272);
      reach = 2 * int'(hits.band_half_width) + 2;
      px = ax + ((bx - ax) * t) / 256 + rand_between(-reach, reach);
      pz = az + ((bz - az) * t) / 256 + rand_between(-reach, reach);
      send_pts(ax, az, bx, bz, px, pz);
    end
  endtask

  // Stop offering, wait until every prediction is answered, then let the
  // pipeline settle.
  task automatic wait_drained();
    @(negedge clk_i);
    in_chan.valid = 1'b0;
    while (hits.pending() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 2) @(posedge clk_i);
  endtask

  // Write the band half width while the block is idle.
  task automatic write_band(logic [RANGE_BITS-1:0] value);
    @(negedge clk_i);
    cfg_chan.valid = 1'b1;
    cfg_chan.data = value;
    do @(posedge clk_i); while (!cfg_chan.ready);
    hits.set_band(value);
    @(negedge clk_i);
    cfg_chan.valid = 1'b0;
  endtask

  // Directed queries aimed at the band edges for particular settings.
  task automatic send_directed(int band);
    case (band)
      64: begin
        // Vertical segment: strict across, inclusive at both ends.
        send_pts(0, 0, 0, 160, 63, 80);
        send_pts(0, 0, 0, 160, 64, 80);
        send_pts(0, 160, 0, 0, -63, 160);
        send_pts(0, 0, 0, 160, 0, 161);
        // Horizontal segment.
        send_pts(-100, 50, 100, 50, 100, 113);
        send_pts(-100, 50, 100, 50, 0, -14);
        send_pts(100, 50, -100, 50, 101, 50);
        // Zero-length segment follows the vertical rule.
        send_pts(5, 5, 5, 5, 5, 5);
        send_pts(5, 5, 5, 5, 68, 5);
        send_pts(5, 5, 5, 5, 5, 6);
        // Slanted segment, both endpoint orders, just past each end.
        send_pts(0, 0, 160, 160, 80, 80);
        send_pts(160, 160, 0, 0, 0, 0);
        send_pts(0, 0, 160, 160, -1, -1);
        send_pts(0, 0, 160, 160, 161, 161);
        // Full-scale coordinates.
        send_pts(-32768, -32768, 32767, 32767, 0, 0);
        send_pts(32767, -32768, -32768, 32767, -32768, -32768);
      end
      0: begin
        // Zero range: axis segments never hit, slanted only on the line.
        send_pts(0, 0, 0, 160, 0, 80);
        send_pts(0, 0, 160, 160, 80, 80);
        send_pts(0, 0, 160, 160, 80, 81);
      end
      80: begin
        // Points at exactly the band distance, at each end of the segment.
        send_pts(0, 0, 48, 64, -64, 48);
        send_pts(0, 0, 48, 64, -65, 48);
        send_pts(0, 0, 48, 64, 112, 16);
      end
      32767: begin
        send_pts(-32768, 0, -32768, 0, -2, 0);
        send_pts(-32768, 0, -32768, 0, -1, 0);
        send_pts(-32768, -32768, 32767, 32767, 32767, -32768);
      end
      default: ;
    endcase
  endtask

  // Stimulus: reset, then one phase per band setting.
  initial begin
    logic [RANGE_BITS-1:0] bands[7];
    rst_ni = 1'b0;
    calm = 1'b0;
    settings_run = 0;
    in_chan.valid = 1'b0;
    in_chan.end_a_x = '0;
    in_chan.end_a_z = '0;
    in_chan.end_b_x = '0;
    in_chan.end_b_z = '0;
    in_chan.query_x = '0;
    in_chan.query_z = '0;
    out_chan.ready = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.data = '0;

    bands[0] = 15'd0;
    bands[1] = 15'd32767;
    bands[2] = 15'd80;
    bands[3] = 15'd1;
    bands[4] = RANGE_BITS'($urandom_range(2, 32766));
    bands[5] = RANGE_BITS'($urandom_range(16, 512));
    bands[6] = RANGE_RESET;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // The reset setting first, then every written setting.
    send_directed(int'(RANGE_RESET));
    repeat (RANDOM_PER_SETTING) send_random_query();
    settings_run++;
    for (int i = 0; i < 7; i++) begin
      wait_drained();
      write_band(bands[i]);
      calm = (i == 2);
      send_directed(int'(bands[i]));
      repeat (RANDOM_PER_SETTING) send_random_query();
      settings_run++;
    end
    calm = 1'b0;
    @(negedge clk_i);
    in_chan.valid = 1'b0;

    wait_drained();
    repeat (2 * PIPE_DEPTH) @(posedge clk_i);

    $display({"Checked %0d queries (%0d hits) over %0d band settings, ",
              "including zero and full scale."},
             hits.checked, hits.hits_seen, settings_run);
    $display("Mismatches: %0d, results still outstanding: %0d",
             hits.mismatches, hits.pending());
    if (hits.mismatches == 0 && hits.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule : tb_top

>>> sim.f
src/pnst_pkg.sv
src/pnst_if.sv
src/pnst_split_mul.sv
src/point_near_segment_test.sv
src/pnst_check.sv
dv/tb_top.sv
